### hw/rtl/nfa_pkg.sv
package nfa_pkg;

	localparam int ID_SPACE_DEF = 256;
	localparam int WORD_W       = 32;
	localparam int OFF_W        = 5;
	localparam logic [7:0] LIMIT_RST = 8'd255;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_LIMIT  = 2'd1,
		ST_NONE   = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_SCAN,
		S_FREE,
		S_OUT
	} state_t;

	typedef enum logic {
		REG_LIMIT = 1'b0,
		REG_NONE  = 1'b1
	} reg_idx_t;

endpackage

### hw/rtl/nfa_ifs.sv
interface nfa_req_if;
	import nfa_pkg::*;

	logic        valid;
	logic        ready;
	func_t       func;
	logic [7:0]  free_id;

	modport source (output valid, func, free_id, input ready);
	modport sink (input valid, func, free_id, output ready);
endinterface

interface nfa_rsp_if;
	import nfa_pkg::*;

	logic        valid;
	logic        ready;
	status_t     status;
	logic [7:0]  peer_id;
	logic [7:0]  in_use_count;

	modport source (output valid, status, peer_id, in_use_count, input ready);
	modport sink (input valid, status, peer_id, in_use_count, output ready);
endinterface

### hw/rtl/nfa_ram.sv
module nfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/next_fit_id_allocator_core.sv
// channel | dir | transfer fields
// --------+-----+---------------------------------
// req     | in  | func, free_id
// rsp     | out | status, peer_id, in_use_count
// apb     | in  | peer_limit at byte address 0
//
// Bitmap lives in a 32-bit-wide RAM, one word per cycle.
// A free reads and rewrites its word; a limit refusal or out-of-range free goes straight
// to the result; an allocate reads words from the start word until a free bit is found
// or every word has been read, and reads the start word again on wrap.
// After reset a clear pass over every bitmap word runs before req.ready rises.
// A new request is taken while a result waits in rsp; the block stalls only in
// its final state until rsp has room.
module next_fit_id_allocator_core #(
	parameter int ID_SPACE = nfa_pkg::ID_SPACE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	nfa_req_if.sink           req,
	nfa_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import nfa_pkg::*;

	localparam int IDW       = $clog2(ID_SPACE);
	localparam int IDP       = IDW + OFF_W;
	localparam int NW        = (ID_SPACE + WORD_W - 1) / WORD_W;
	localparam int WAW       = (NW > 1) ? $clog2(NW) : 1;
	localparam int VW        = $clog2(NW + 2);
	localparam int LAST_BITS = ID_SPACE - (NW - 1) * WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK =
		(LAST_BITS == WORD_W) ? '1 : ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

	state_t state_q, state_d;

	logic [7:0]        limit_q;
	logic [7:0]        cnt_q;
	logic [IDW-1:0]    last_q;
	logic [WAW-1:0]    clr_q;
	logic [WAW-1:0]    wq_q;
	logic [OFF_W-1:0]  off_q;
	logic              first_q;
	logic [VW-1:0]     vis_q;
	status_t           res_status_q;
	logic [7:0]        res_id_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [7:0]        out_id_q;
	logic [7:0]        out_cnt_q;

	logic              ram_we;
	logic [WAW-1:0]    ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [WAW-1:0]    ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic              req_fire;
	logic              out_room;
	logic              limit_hit;
	logic              free_oor;
	logic [IDW-1:0]    start_id;
	logic [IDP-1:0]    start_p;
	logic [IDP-1:0]    free_p;
	logic [WAW-1:0]    next_w;
	logic [WORD_W-1:0] vmask;
	logic [WORD_W-1:0] cand;
	logic              found;
	logic [OFF_W-1:0]  fbit;
	logic [IDW-1:0]    found_id;
	logic              scan_end;
	logic              free_hit;

	nfa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NW),
		.AW   (WAW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_room  = !out_valid_q || rsp.ready;
	assign limit_hit = (cnt_q >= limit_q);
	assign free_oor  = (32'(req.free_id) >= 32'(ID_SPACE));

	assign start_id = (last_q == IDW'(ID_SPACE - 1)) ? '0 : last_q + IDW'(1);
	assign start_p  = IDP'(start_id);
	assign free_p   = IDP'(IDW'(req.free_id));
	assign next_w   = (wq_q == WAW'(NW - 1)) ? '0 : wq_q + WAW'(1);

	always_comb begin
		vmask = '1;
		if (wq_q == WAW'(NW - 1)) begin
			vmask = vmask & LAST_MASK;
		end
		if (wq_q == '0) begin
			vmask[0] = 1'b0;
		end
		if (first_q) begin
			vmask = vmask & ('1 << off_q);
		end
	end

	assign cand = ~ram_rdata & vmask;

	always_comb begin
		found = 1'b0;
		fbit  = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				found = 1'b1;
				fbit  = OFF_W'(b);
			end
		end
	end

	assign found_id = IDW'((IDP'(wq_q) << OFF_W) | IDP'(fbit));
	assign scan_end = (vis_q == VW'(NW));
	assign free_hit = ram_rdata[off_q];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_q == WAW'(NW - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					if (req.func == FN_FREE) begin
						state_d = free_oor ? S_OUT : S_FREE;
					end else begin
						state_d = limit_hit ? S_OUT : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (found || scan_end) begin
					state_d = S_OUT;
				end
			end
			S_FREE: state_d = S_OUT;
			S_OUT: begin
				if (out_room) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wq_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = next_w;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_re    = req_fire;
				ram_raddr = (req.func == FN_FREE) ? WAW'(free_p >> OFF_W)
				                                  : WAW'(start_p >> OFF_W);
			end
			S_SCAN: begin
				if (found) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (WORD_W'(1) << fbit);
				end else if (!scan_end) begin
					ram_re = 1'b1;
				end
			end
			S_FREE: begin
				ram_we    = free_hit;
				ram_wdata = ram_rdata & ~(WORD_W'(1) << off_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			limit_q <= LIMIT_RST;
			cnt_q   <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + WAW'(1);
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
				limit_q <= pwdata[7:0];
			end
			if (state_q == S_SCAN && found) begin
				last_q <= found_id;
				cnt_q  <= cnt_q + 8'd1;
			end
			if (state_q == S_FREE && free_hit && cnt_q != '0) begin
				cnt_q <= cnt_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				first_q      <= 1'b1;
				vis_q        <= '0;
				res_id_q     <= '0;
				if (req.func == FN_FREE) begin
					wq_q         <= WAW'(free_p >> OFF_W);
					off_q        <= free_p[OFF_W-1:0];
					res_status_q <= ST_UNUSED;
				end else begin
					wq_q         <= WAW'(start_p >> OFF_W);
					off_q        <= start_p[OFF_W-1:0];
					res_status_q <= ST_LIMIT;
				end
			end
			S_SCAN: begin
				if (found) begin
					res_status_q <= ST_OK;
					res_id_q     <= 8'(found_id);
				end else begin
					res_status_q <= ST_NONE;
					wq_q         <= next_w;
					first_q      <= 1'b0;
					vis_q        <= vis_q + VW'(1);
				end
			end
			S_FREE: begin
				res_status_q <= free_hit ? ST_OK : ST_UNUSED;
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_room) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_room) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_cnt_q    <= cnt_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.peer_id      = out_id_q;
	assign rsp.in_use_count = out_cnt_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? {24'd0, limit_q} : 32'd0;

endmodule

### tb/next_fit_id_allocator_core_test.sv
`timescale 1ns / 1ps

module next_fit_id_allocator_core_test;
	import nfa_pkg::*;

	localparam int SPACE = ID_SPACE_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE = SPACE / WORD_W + 6;
	localparam logic [2:0] LIMIT_ADDR = 3'(4 * int'(REG_LIMIT));
	localparam int HOLD_AFTER = 200;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		func_t      func;
		logic [7:0] free_id;
	} request_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] peer_id;
		logic [7:0] in_use_count;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	nfa_req_if req();
	nfa_rsp_if rsp();

	next_fit_id_allocator_core #(
		.ID_SPACE(SPACE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// allocator state as seen from the outside
	bit          id_taken [SPACE];
	int unsigned last_id = 0;
	int unsigned in_use = 0;
	logic [7:0]  limit_cfg = LIMIT_RST;

	request_t    pending [$];
	outcome_t    expected_outcomes [$];
	request_t    next_req;
	outcome_t    want;
	int          issued = 0;
	int          taken = 0;
	int          answered = 0;
	int          errors = 0;
	int          cycles = 0;
	int          limits_set = 0;
	int          status_seen [4] = '{0, 0, 0, 0};
	bit          no_idle = 1'b0;
	logic        req_fire = 1'b0;
	int          req_gap = 0;
	int          rsp_gap = 0;
	int          hold_left = 0;
	bit          held_once = 1'b0;

	function automatic outcome_t serve_request(func_t fn, logic [7:0] id);
		outcome_t    res;
		int unsigned cand;
		res.status = ST_OK;
		res.peer_id = '0;
		if (fn == FN_ALLOC) begin
			if (in_use >= limit_cfg) begin
				res.status = ST_LIMIT;
			end else begin
				res.status = ST_NONE;
				cand = last_id;
				for (int n = 0; n < SPACE; n++) begin
					cand = (cand + 1) % SPACE;
					if (cand != 0 && !id_taken[cand]) begin
						id_taken[cand] = 1'b1;
						last_id = cand;
						in_use = (in_use + 1) % 256;
						res.status = ST_OK;
						res.peer_id = 8'(cand);
						break;
					end
				end
			end
		end else if (int'(id) >= SPACE || !id_taken[id]) begin
			res.status = ST_UNUSED;
		end else begin
			id_taken[id] = 1'b0;
			if (in_use > 0)
				in_use--;
		end
		res.in_use_count = 8'(in_use);
		return res;
	endfunction

	function automatic logic [7:0] pick_release_id();
		int r;
		int start;
		r = $urandom_range(99);
		if (r < 70) begin
			start = $urandom_range(SPACE - 1);
			for (int k = 0; k < SPACE; k++)
				if (id_taken[(start + k) % SPACE])
					return 8'((start + k) % SPACE);
		end
		if (r < 78)
			return 8'd0;
		if (r < 84)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 72)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 45);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
		errors++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_fire) begin
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req.valid <= 1'b0;
			end else if (pending.size() > 0) begin
				next_req = pending.pop_front();
				req.func <= next_req.func;
				req.free_id <= next_req.free_id;
				req.valid <= 1'b1;
				req_gap <= pick_gap();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// response back-pressure, with one long hold once traffic is under way
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else if (!held_once && taken >= HOLD_AFTER) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
			rsp_gap <= pick_gap();
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		req_fire <= req.valid && req.ready;
		if (arst_n && rsp.valid && rsp.ready) begin
			answered++;
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected transfer, status", int'(rsp.status), -1);
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.peer_id !== want.peer_id)
					report_mismatch("peer_id", int'(rsp.peer_id), int'(want.peer_id));
				if (rsp.in_use_count !== want.in_use_count)
					report_mismatch("in_use_count", int'(rsp.in_use_count),
						int'(want.in_use_count));
				status_seen[want.status]++;
			end
		end
		if (arst_n && req.valid && req.ready) begin
			expected_outcomes.push_back(serve_request(req.func, req.free_id));
			taken++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d of %0d transfers answered",
				cycles, answered, issued);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_req(input func_t fn, input logic [7:0] id);
		pending.push_back('{func: fn, free_id: id});
		issued++;
	endtask

	task automatic wait_taken();
		while (taken != issued)
			@(negedge clk);
	endtask

	task automatic wait_quiet();
		while (answered != issued || expected_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = LIMIT_ADDR;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_limit_reg(input logic [7:0] v);
		logic [31:0] rd;
		apb_access(1'b0, 32'($urandom), rd);
		if (rd !== {24'd0, v})
			report_mismatch("peer_limit readback", int'(rd), int'(v));
	endtask

	task automatic set_peer_limit(input logic [7:0] v);
		logic [31:0] rd;
		wait_quiet();
		apb_access(1'b1, {24'($urandom), v}, rd);
		limit_cfg = v;
		limits_set++;
		check_limit_reg(v);
	endtask

	task automatic run_phase(input logic [7:0] lim, input int alloc_pct, input int n_items,
			input bit steady);
		int left;
		int batch;
		set_peer_limit(lim);
		no_idle = steady;
		left = n_items;
		while (left > 0) begin
			batch = $urandom_range(1, 16);
			if (batch > left)
				batch = left;
			left -= batch;
			repeat (batch) begin
				if ($urandom_range(99) < alloc_pct)
					push_req(FN_ALLOC, 8'($urandom));
				else
					push_req(FN_FREE, pick_release_id());
			end
			wait_taken();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		req.valid = 1'b0;
		req.func = FN_ALLOC;
		req.free_id = '0;
		rsp.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_limit_reg(LIMIT_RST);

		// directed: frees of unused ids, next-fit order, refusal at the limit
		push_req(FN_FREE, 8'd0);
		push_req(FN_FREE, 8'hFF);
		push_req(FN_FREE, 8'd1);
		push_req(FN_ALLOC, 8'hFF);
		push_req(FN_ALLOC, 8'd0);
		push_req(FN_ALLOC, 8'hA5);
		push_req(FN_FREE, 8'd2);
		push_req(FN_FREE, 8'd2);
		push_req(FN_ALLOC, 8'h5A);
		push_req(FN_FREE, 8'd3);
		push_req(FN_ALLOC, 8'h00);
		push_req(FN_FREE, 8'd128);
		wait_taken();
		set_peer_limit(8'd0);
		push_req(FN_ALLOC, 8'd0);
		push_req(FN_FREE, 8'd1);
		push_req(FN_ALLOC, 8'hFF);
		wait_taken();
		set_peer_limit(8'd4);
		push_req(FN_ALLOC, 8'd7);
		push_req(FN_ALLOC, 8'd7);
		push_req(FN_ALLOC, 8'd7);
		push_req(FN_FREE, 8'd4);
		push_req(FN_ALLOC, 8'd7);
		push_req(FN_FREE, 8'hFF);
		wait_taken();

		run_phase(8'd255, 90, 320, 1'b0);
		run_phase(8'd255, 20, 150, 1'b1);
		run_phase(8'd1, 50, 60, 1'b0);
		run_phase(8'($urandom_range(2, 254)), 55, 120, 1'b0);
		run_phase(8'd128, 60, 120, 1'b0);
		run_phase(8'd0, 50, 30, 1'b0);
		run_phase(8'($urandom), 60, 60, 1'b0);

		wait_quiet();
		$display("Covered %0d requests over %0d limit settings, incl. a full map and wrap",
			issued, limits_set);
		$display("Results: %0d ok, %0d refused at limit, %0d no free id, %0d unused frees",
			status_seen[ST_OK], status_seen[ST_LIMIT], status_seen[ST_NONE],
			status_seen[ST_UNUSED]);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
